// ===== rtl/qcao_pkg.sv =====
// ----------------------------------------------------------------------------
// qcao_pkg: shared types and constants for the quad corner orderer
// Coordinate widths, offset and cross-product widths, and the corner pairs
// that the comparison network looks at.
// ----------------------------------------------------------------------------
`default_nettype none

package qcao_pkg;

    localparam int COORD_BITS = 16;
    localparam int OFF_BITS   = COORD_BITS + 3;
    localparam int PROD_BITS  = 2 * OFF_BITS;
    localparam int NCORNERS   = 4;
    localparam int IDX_BITS   = 2;
    localparam int NPAIRS     = 6;

    localparam int PAIR_A [NPAIRS] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_B [NPAIRS] = '{1, 2, 3, 2, 3, 3};

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [OFF_BITS-1:0]   t_off;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic        [IDX_BITS-1:0]   t_idx;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    // Products of one corner pair a < b: p = ax * by, q = ay * bx.
    typedef struct packed {
        t_prod p;
        t_prod q;
    } t_cross;

    typedef t_point [NCORNERS-1:0] t_point_vec;
    typedef t_cross [NPAIRS-1:0]   t_cross_vec;
    typedef t_idx   [NCORNERS-1:0] t_idx_vec;

endpackage

`default_nettype wire

// ===== rtl/qcao_rank.sv =====
// ----------------------------------------------------------------------------
// qcao_rank: angular rank of each corner
// Compares every pair of corners by half-plane and cross-product sign and
// counts, for each corner, how many corners precede it in stable order.
// ----------------------------------------------------------------------------
`default_nettype none

module qcao_rank (
    input  wire logic [qcao_pkg::NCORNERS-1:0] i_half,
    input  wire qcao_pkg::t_cross_vec          i_cross,
    output qcao_pkg::t_idx_vec                 o_pos
);
    import qcao_pkg::*;

    logic [NPAIRS-1:0] b_first;

    always_comb begin
        for (int k = 0; k < NPAIRS; k++) begin
            if (i_half[PAIR_A[k]] != i_half[PAIR_B[k]]) begin
                b_first[k] = i_half[PAIR_B[k]] < i_half[PAIR_A[k]];
            end else begin
                b_first[k] = i_cross[k].q > i_cross[k].p;
            end
        end
    end

    always_comb begin
        o_pos = '0;
        for (int k = 0; k < NPAIRS; k++) begin
            if (b_first[k]) begin
                o_pos[PAIR_A[k]] = o_pos[PAIR_A[k]] + t_idx'(1);
            end else begin
                o_pos[PAIR_B[k]] = o_pos[PAIR_B[k]] + t_idx'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/quad_corner_angle_order.sv =====
// ----------------------------------------------------------------------------
// quad_corner_angle_order: polar-angle ordering of four quad corners
// Sorts the corners by angle around their centroid and rotates the list so
// that the top-left corner comes first.
// ----------------------------------------------------------------------------
// A beat carries four signed Q12.4 corners and yields one beat of four
// ordered corners. The block is a three-stage pipeline (input register,
// centroid offsets and cross products, then ranking and reordering into the
// output register), so a result beat passes through these registers in that
// order, and one beat is accepted every cycle while the output side keeps
// up.
// Each stage holds its beat only while the stage after it is full and
// stalled, so up to three beats can be in flight.
`default_nettype none

module quad_corner_angle_order (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire qcao_pkg::t_coord i_corner0_x,
    input  wire qcao_pkg::t_coord i_corner0_y,
    input  wire qcao_pkg::t_coord i_corner1_x,
    input  wire qcao_pkg::t_coord i_corner1_y,
    input  wire qcao_pkg::t_coord i_corner2_x,
    input  wire qcao_pkg::t_coord i_corner2_y,
    input  wire qcao_pkg::t_coord i_corner3_x,
    input  wire qcao_pkg::t_coord i_corner3_y,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output qcao_pkg::t_coord      o_ordered0_x,
    output qcao_pkg::t_coord      o_ordered0_y,
    output qcao_pkg::t_coord      o_ordered1_x,
    output qcao_pkg::t_coord      o_ordered1_y,
    output qcao_pkg::t_coord      o_ordered2_x,
    output qcao_pkg::t_coord      o_ordered2_y,
    output qcao_pkg::t_coord      o_ordered3_x,
    output qcao_pkg::t_coord      o_ordered3_y
);
    import qcao_pkg::*;

    logic en1, en2, en3;

    logic        r1_v, r2_v, r3_v;
    t_point_vec  r1_pt, r2_pt, r3_pt;
    t_point_vec  n1_pt, n3_pt;

    logic [NCORNERS-1:0] n2_half, r2_half;
    t_cross_vec          n2_cross, r2_cross;
    t_idx                n2_tl, r2_tl;

    t_off     sum_x, sum_y;
    t_off     dx [NCORNERS];
    t_off     dy [NCORNERS];
    t_idx_vec pos;
    t_idx     start;
    t_idx     sel;

    assign en3     = !r3_v || i_ready;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign o_ready = en1;
    assign o_valid = r3_v;

    assign n1_pt[0] = '{x: i_corner0_x, y: i_corner0_y};
    assign n1_pt[1] = '{x: i_corner1_x, y: i_corner1_y};
    assign n1_pt[2] = '{x: i_corner2_x, y: i_corner2_y};
    assign n1_pt[3] = '{x: i_corner3_x, y: i_corner3_y};

    // Offsets are four times the distance from the centroid, kept exact.
    always_comb begin
        sum_x = '0;
        sum_y = '0;
        for (int i = 0; i < NCORNERS; i++) begin
            sum_x = sum_x + t_off'(r1_pt[i].x);
            sum_y = sum_y + t_off'(r1_pt[i].y);
        end
        for (int i = 0; i < NCORNERS; i++) begin
            dx[i] = (t_off'(r1_pt[i].x) <<< 2) - sum_x;
            dy[i] = (t_off'(r1_pt[i].y) <<< 2) - sum_y;
            if (dx[i] == '0 && dy[i] == '0) begin
                dx[i] = t_off'(1);
            end
            if (dy[i] < 0) begin
                n2_half[i] = 1'b0;
            end else if (dy[i] > 0) begin
                n2_half[i] = 1'b1;
            end else begin
                n2_half[i] = dx[i] < 0;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < NPAIRS; k++) begin
            n2_cross[k].p = t_prod'(dx[PAIR_A[k]]) * t_prod'(dy[PAIR_B[k]]);
            n2_cross[k].q = t_prod'(dy[PAIR_A[k]]) * t_prod'(dx[PAIR_B[k]]);
        end
    end

    // Identical corners keep input order, so the lowest input index wins ties.
    always_comb begin
        n2_tl = '0;
        for (int i = 1; i < NCORNERS; i++) begin
            if (r1_pt[i].y < r1_pt[n2_tl].y ||
                (r1_pt[i].y == r1_pt[n2_tl].y && r1_pt[i].x < r1_pt[n2_tl].x)) begin
                n2_tl = t_idx'(i);
            end
        end
    end

    qcao_rank u_rank (
        .i_half  (r2_half),
        .i_cross (r2_cross),
        .o_pos   (pos)
    );

    assign start = pos[r2_tl];

    always_comb begin
        n3_pt = r2_pt;
        sel   = '0;
        for (int k = 0; k < NCORNERS; k++) begin
            sel = t_idx'(k) + start;
            for (int i = 0; i < NCORNERS; i++) begin
                if (pos[i] == sel) begin
                    n3_pt[k] = r2_pt[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            if (en1) begin
                r1_v <= i_valid;
            end
            if (en2) begin
                r2_v <= r1_v;
            end
            if (en3) begin
                r3_v <= r2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_pt <= n1_pt;
        end
        if (en2) begin
            r2_pt    <= r1_pt;
            r2_half  <= n2_half;
            r2_cross <= n2_cross;
            r2_tl    <= n2_tl;
        end
        if (en3) begin
            r3_pt <= n3_pt;
        end
    end

    assign o_ordered0_x = r3_pt[0].x;
    assign o_ordered0_y = r3_pt[0].y;
    assign o_ordered1_x = r3_pt[1].x;
    assign o_ordered1_y = r3_pt[1].y;
    assign o_ordered2_x = r3_pt[2].x;
    assign o_ordered2_y = r3_pt[2].y;
    assign o_ordered3_x = r3_pt[3].x;
    assign o_ordered3_y = r3_pt[3].y;

endmodule

`default_nettype wire

// ===== rtl/qcao_checker.sv =====
// ----------------------------------------------------------------------------
// qcao_checker: port-level assertions for the quad corner orderer
// Tracks beats in flight and checks stall behavior and top-left ordering.
// ----------------------------------------------------------------------------
`default_nettype none

module qcao_checker (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic             o_ready,
    input  wire logic             o_valid,
    input  wire logic             i_ready,
    input  wire qcao_pkg::t_coord o_ordered0_x,
    input  wire qcao_pkg::t_coord o_ordered0_y,
    input  wire qcao_pkg::t_coord o_ordered1_x,
    input  wire qcao_pkg::t_coord o_ordered1_y,
    input  wire qcao_pkg::t_coord o_ordered2_x,
    input  wire qcao_pkg::t_coord o_ordered2_y,
    input  wire qcao_pkg::t_coord o_ordered3_x,
    input  wire qcao_pkg::t_coord o_ordered3_y
);
    import qcao_pkg::*;

    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic       in_beat, out_beat;

    assign in_beat  = i_valid && o_ready;
    assign out_beat = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (in_beat && !out_beat) begin
            n_cnt = r_cnt + 3'd1;
        end else if (out_beat && !in_beat) begin
            n_cnt = r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_ordered0_x) &&
            $stable(o_ordered0_y) && $stable(o_ordered1_x) && $stable(o_ordered1_y) &&
            $stable(o_ordered2_x) && $stable(o_ordered2_y) && $stable(o_ordered3_x) &&
            $stable(o_ordered3_y))
        else $error("Output beat changed while stalled.");

    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= 3'd3) && (!o_valid || r_cnt != 3'd0))
        else $error("Beats in flight out of range.");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 3'd0 |-> o_ready)
        else $error("Input not ready while the pipeline is empty.");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 3'd3 && o_valid && !i_ready |-> !o_ready)
        else $error("Input ready while the pipeline is full and stalled.");

    a_top_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (o_ordered0_y < o_ordered1_y ||
                (o_ordered0_y == o_ordered1_y && o_ordered0_x <= o_ordered1_x)) &&
            (o_ordered0_y < o_ordered2_y ||
                (o_ordered0_y == o_ordered2_y && o_ordered0_x <= o_ordered2_x)) &&
            (o_ordered0_y < o_ordered3_y ||
                (o_ordered0_y == o_ordered3_y && o_ordered0_x <= o_ordered3_x)))
        else $error("First output corner is not the top-left corner.");

endmodule

bind quad_corner_angle_order qcao_checker u_qcao_checker (.*);

`default_nettype wire
